// ===== rtl/core/mexp_pkg.sv =====
package mexp_pkg;

   // Width of every field on the ports
   localparam int MEXP_FIELD_W = 32;

   // Default operand width inside the block
   localparam int MEXP_WIDTH_DEFAULT = 32;

   // Modulus after reset
   localparam int MEXP_MOD_RESET = 23;

   // Values returned without any arithmetic
   localparam int MEXP_ONE  = 1;
   localparam int MEXP_ZERO = 0;

   // Engine status seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
   } mexp_status_type;

endpackage

// ===== rtl/core/mexp_step_unit.sv =====
module mexp_step_unit
   import mexp_pkg::*;
#(
   parameter int WIDTH = MEXP_WIDTH_DEFAULT
) (
   input  logic [WIDTH-1:0] modulus,
   input  logic [WIDTH-1:0] acc_value,
   input  logic [WIDTH-1:0] addend_value,
   input  logic             add_enable,
   input  logic             carry_in,
   output logic [WIDTH-1:0] acc_next,
   output logic [WIDTH-1:0] addend_next
);

   localparam int SUM_W = WIDTH + 2;

   logic [SUM_W-1:0] mod_ext;
   logic [SUM_W-1:0] acc_sum;
   logic [SUM_W-1:0] acc_red;
   logic [SUM_W-1:0] dbl_sum;
   logic [SUM_W-1:0] dbl_red;

   assign mod_ext = {2'b00, modulus};

   // Accumulate: acc + addend mod m, both operands below m
   always_comb begin
      acc_sum = {2'b00, acc_value} + {2'b00, addend_value};
      if (acc_sum >= mod_ext) begin
         acc_red = acc_sum - mod_ext;
      end else begin
         acc_red = acc_sum;
      end
   end

   // Double with carry in: 2 * addend + cin mod m, stays below 2m
   always_comb begin
      dbl_sum = {1'b0, addend_value, carry_in};
      if (dbl_sum >= mod_ext) begin
         dbl_red = dbl_sum - mod_ext;
      end else begin
         dbl_red = dbl_sum;
      end
   end

   assign acc_next    = add_enable ? acc_red[WIDTH-1:0] : acc_value;
   assign addend_next = dbl_red[WIDTH-1:0];

endmodule

// ===== rtl/core/mexp_engine.sv =====
module mexp_engine
   import mexp_pkg::*;
#(
   parameter int WIDTH = MEXP_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] base_value,
   input  logic [WIDTH-1:0] exponent,
   input  logic [WIDTH-1:0] modulus,
   input  logic             out_free,
   output mexp_status_type  status,
   output logic [WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SELECT,
      ST_MUL,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sq_phase_ff, sq_phase_in;
   logic             mul_sq_ff, mul_sq_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] mul_acc_ff, mul_acc_in;
   logic [WIDTH-1:0] mul_add_ff, mul_add_in;
   logic [WIDTH-1:0] mul_b_ff, mul_b_in;

   logic [WIDTH-1:0] unit_addend;
   logic             unit_cin;
   logic [WIDTH-1:0] unit_acc_next;
   logic [WIDTH-1:0] unit_addend_next;
   logic             exp_rest_zero;

   // Share one step unit between base reduction and multiplication
   assign unit_addend = (state_ff == ST_REDUCE) ? sq_ff : mul_add_ff;
   assign unit_cin    = (state_ff == ST_REDUCE) ? shift_ff[WIDTH-1] : 1'b0;

   mexp_step_unit #(
      .WIDTH (WIDTH)
   ) u_step (
      .modulus      (modulus),
      .acc_value    (mul_acc_ff),
      .addend_value (unit_addend),
      .add_enable   (mul_b_ff[0]),
      .carry_in     (unit_cin),
      .acc_next     (unit_acc_next),
      .addend_next  (unit_addend_next)
   );

   assign exp_rest_zero = (exp_ff[WIDTH-1:1] == '0);

   // Sequence reduction, multiplies and squarings
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sq_phase_in = sq_phase_ff;
      mul_sq_in   = mul_sq_ff;
      shift_in    = shift_ff;
      exp_in      = exp_ff;
      sq_in       = sq_ff;
      acc_in      = acc_ff;
      mul_acc_in  = mul_acc_ff;
      mul_add_in  = mul_add_ff;
      mul_b_in    = mul_b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               shift_in    = base_value;
               exp_in      = exponent;
               sq_in       = '0;
               cnt_in      = '0;
               sq_phase_in = 1'b0;
               if (modulus == '0) begin
                  acc_in   = WIDTH'(MEXP_ZERO);
                  state_in = ST_FINISH;
               end else if (exponent == '0) begin
                  acc_in   = WIDTH'(MEXP_ONE);
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = (modulus == WIDTH'(MEXP_ONE)) ? WIDTH'(MEXP_ZERO)
                                                           : WIDTH'(MEXP_ONE);
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            // Shift base bits in from the top, reducing at each step
            sq_in    = unit_addend_next;
            shift_in = {shift_ff[WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            mul_acc_in = '0;
            if (exp_ff[0] && !sq_phase_ff) begin
               mul_add_in = acc_ff;
               mul_b_in   = sq_ff;
               mul_sq_in  = 1'b0;
               state_in   = ST_MUL;
            end else if (exp_rest_zero) begin
               state_in = ST_FINISH;
            end else begin
               mul_add_in = sq_ff;
               mul_b_in   = sq_ff;
               mul_sq_in  = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_b_ff == '0) begin
               // Product complete: write back and pick the next step
               if (mul_sq_ff) begin
                  sq_in       = mul_acc_ff;
                  exp_in      = {1'b0, exp_ff[WIDTH-1:1]};
                  sq_phase_in = 1'b0;
               end else begin
                  acc_in      = mul_acc_ff;
                  sq_phase_in = 1'b1;
               end
               state_in = ST_SELECT;
            end else begin
               mul_acc_in = unit_acc_next;
               mul_add_in = unit_addend_next;
               mul_b_in   = {1'b0, mul_b_ff[WIDTH-1:1]};
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sq_phase_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sq_phase_ff <= sq_phase_in;
      end
      cnt_ff     <= cnt_in;
      mul_sq_ff  <= mul_sq_in;
      shift_ff   <= shift_in;
      exp_ff     <= exp_in;
      sq_ff      <= sq_in;
      acc_ff     <= acc_in;
      mul_acc_ff <= mul_acc_in;
      mul_add_ff <= mul_add_in;
      mul_b_ff   <= mul_b_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_FINISH) && out_free;
   assign result      = acc_ff;

endmodule

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: power_result = base_value ^ exponent mod modulus.
// Request channel (req_*): base_value and exponent; an item is taken when
// req_valid is high and req_stall is low. req_stall stays high while an item
// is being worked on, so one item is in flight at a time.
// Response channel (rsp_*): one power_result per item, held in an output
// register; it stays put while rsp_stall is high. A new item is taken while
// a finished result still waits in that register.
// The modulus is written through csr_write_enable / csr_write_data; the user
// must write it only while the unit is idle, as the block does not enforce it.
// A zero modulus gives 0; otherwise a zero exponent gives 1.
// The base is reduced one bit per cycle, then each exponent bit up to the
// highest set one costs a select step and one modular multiply for a set
// bit, then a select step and one squaring (except after the top bit), plus
// one last select step. Each multiply runs one multiplier bit per cycle
// through the shared add/double unit.
// Reset returns the engine to idle, clears rsp_valid and loads modulus 23.
module modular_exponentiation_unit
   import mexp_pkg::*;
#(
   parameter int WIDTH = MEXP_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MEXP_FIELD_W-1:0] req_base_value,
   input  logic [MEXP_FIELD_W-1:0] req_exponent,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [MEXP_FIELD_W-1:0] rsp_power_result,
   input  logic                    csr_write_enable,
   input  logic [MEXP_FIELD_W-1:0] csr_write_data
);

   logic [WIDTH-1:0]        modulus_ff, modulus_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MEXP_FIELD_W-1:0] rsp_data_ff, rsp_data_in;

   mexp_status_type  eng_status;
   logic [WIDTH-1:0] eng_result;
   logic             req_take;
   logic             out_free;

   assign req_take = req_valid && !eng_status.busy;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   mexp_engine #(
      .WIDTH (WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take),
      .base_value (WIDTH'(req_base_value)),
      .exponent   (WIDTH'(req_exponent)),
      .modulus    (modulus_ff),
      .out_free   (out_free),
      .status     (eng_status),
      .result     (eng_result)
   );

   // Load the modulus on a write
   assign modulus_in = csr_write_enable ? WIDTH'(csr_write_data) : modulus_ff;

   // Load a finished result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = MEXP_FIELD_W'(eng_result);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WIDTH'(MEXP_MOD_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall        = eng_status.busy;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule

// ===== rtl/core/mexp_checker.sv =====
module mexp_checker
   import mexp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [MEXP_FIELD_W-1:0] req_exponent,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [MEXP_FIELD_W-1:0] rsp_power_result
);

   // Reset leaves the unit idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("unit not idle after reset");

   // An accepted item keeps the unit busy on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("unit took no notice of an accepted item");

   // A zero exponent with an empty output goes from the finish state straight into the output register
   a_zero_exp_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid && req_exponent == '0
      |-> ##2 rsp_valid)
      else $error("zero exponent result late");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_result))
      else $error("stalled result changed");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_exponent     (req_exponent),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_power_result (rsp_power_result)
);

// ===== dv/tb_modular_exponentiation_unit.sv =====
`timescale 1ns / 100ps

module tb_modular_exponentiation_unit
   import mexp_pkg::*;
;

   typedef logic [MEXP_FIELD_W-1:0] word_type;

   typedef struct {
      word_type base_value;
      word_type exponent;
   } power_request_type;

   logic     clock            = 1'b0;
   logic     reset            = 1'b1;
   logic     req_valid        = 1'b0;
   logic     req_stall;
   word_type req_base_value   = '0;
   word_type req_exponent     = '0;
   logic     rsp_valid;
   logic     rsp_stall        = 1'b0;
   word_type rsp_power_result;
   logic     csr_write_enable = 1'b0;
   word_type csr_write_data   = '0;

   power_request_type pending_requests[$];
   word_type          expected_powers[$];
   word_type          active_modulus = MEXP_MOD_RESET;
   bit                quiet_stretch = 1'b0;
   int                mismatch_count = 0;
   int                results_seen = 0;
   int                hold_off_left = 0;
   bit                hold_off_done = 1'b0;

   modular_exponentiation_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Right-to-left square-and-multiply; products are formed exactly in 64 bits
   function automatic word_type predict_power(word_type base_value, word_type exponent,
                                              word_type modulus);
      logic [63:0] m;
      logic [63:0] running;
      logic [63:0] square;
      word_type    bits_left;
      if (modulus == '0)
         return MEXP_ZERO;
      if (exponent == '0)
         return MEXP_ONE;
      m         = 64'(modulus);
      running   = 64'd1 % m;
      square    = 64'(base_value) % m;
      bits_left = exponent;
      while (bits_left != '0) begin
         if (bits_left[0])
            running = (running * square) % m;
         bits_left = bits_left >> 1;
         square    = (square * square) % m;
      end
      return running[MEXP_FIELD_W-1:0];
   endfunction

   task automatic report_mismatch(string detail);
      $display("[%0t] MISMATCH: %s", $realtime, detail);
      mismatch_count++;
   endtask

   task automatic queue_request(word_type base_value, word_type exponent);
      power_request_type item;
      item.base_value = base_value;
      item.exponent   = exponent;
      pending_requests.push_back(item);
   endtask

   // Most exponents are short to keep the run quick; about a quarter use all 32 bits
   task automatic queue_random_requests(int count);
      word_type base_value;
      word_type exponent;
      int       roll;
      repeat (count) begin
         roll = $urandom_range(99);
         case ($urandom_range(9))
            0:       base_value = '0;
            1:       base_value = active_modulus - 1;
            2:       base_value = active_modulus;
            3:       base_value = '1;
            default: base_value = $urandom;
         endcase
         if (roll < 25)
            exponent = $urandom;
         else if (roll < 35)
            exponent = $urandom_range(2);
         else
            exponent = $urandom & ((32'd1 << $urandom_range(12, 1)) - 1);
         queue_request(base_value, exponent);
      end
   endtask

   // Wait until every item is taken and answered, then let the engine settle
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_valid || expected_powers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_modulus(word_type value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_modulus = value;
   endtask

   // Sender: log each item the block takes, then offer the next one or hold
   always @(posedge clock) begin : drive_requests
      power_request_type next_item;
      bit                offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_powers.push_back(
               predict_power(req_base_value, req_exponent, active_modulus));
         if (!req_valid || !req_stall) begin
            offer = pending_requests.size() != 0 &&
                    (quiet_stretch || $urandom_range(99) >= 33);
            if (offer) begin
               next_item = pending_requests.pop_front();
               req_valid      <= 1'b1;
               req_base_value <= next_item.base_value;
               req_exponent   <= next_item.exponent;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Hold the receiver off once for longer than one full item so the block backs up
   always @(posedge clock) begin : count_hold_off
      if (reset) begin
         hold_off_left <= 0;
      end else if (!hold_off_done && results_seen >= 40) begin
         hold_off_left <= 4000;
         hold_off_done <= 1'b1;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   // Receiver: check each result against the oldest prediction, then pick the stall
   always @(posedge clock) begin : check_results
      word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               report_mismatch($sformatf("power_result %h with no item outstanding",
                                         rsp_power_result));
            end else begin
               want = expected_powers.pop_front();
               if (rsp_power_result !== want)
                  report_mismatch($sformatf("power_result got %h, want %h",
                                            rsp_power_result, want));
            end
            results_seen++;
         end
         rsp_stall <= (hold_off_left != 0) ||
                      (!quiet_stretch && ($urandom_range(99) < 33));
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset modulus: zero exponent, zero base, all-ones fields, top bits
      queue_request('0, '0);
      queue_request(32'd5, '0);
      queue_request('0, 32'd5);
      queue_request('1, '1);
      queue_request('1, 32'd1);
      queue_request(32'd2, 32'd1);
      queue_request(32'd23, 32'd3);
      queue_request(32'd46, '1);
      queue_request(32'd1, '1);
      queue_request(32'h8000_0000, 32'h8000_0000);
      queue_request(32'd7, 32'd22);
      queue_request(32'd3, 32'h7FFF_FFFF);
      wait_until_drained();

      // Modulus one: zero exponent still gives one, anything else zero
      write_modulus(32'd1);
      queue_request(32'd5, '0);
      queue_request(32'd5, 32'd3);
      queue_request('1, '1);
      wait_until_drained();

      // Largest modulus
      write_modulus('1);
      queue_request('1, 32'd5);
      queue_request(32'hFFFF_FFFE, '1);
      queue_request(32'd2, 32'd32);
      queue_request(32'h1234_5678, 32'h0000_FFFF);
      wait_until_drained();

      // Zero modulus gives zero for every exponent
      write_modulus('0);
      queue_request('0, '0);
      queue_request(32'd7, '0);
      queue_request(32'd7, 32'd9);
      wait_until_drained();

      // Random items across several moduli; the receiver hold-off lands in the first
      write_modulus(32'hFFFF_FFFB);
      queue_random_requests(60);
      wait_until_drained();

      quiet_stretch = 1'b1;
      write_modulus($urandom | 32'h8000_0000);
      queue_random_requests(60);
      wait_until_drained();
      quiet_stretch = 1'b0;

      write_modulus($urandom_range(1000, 2));
      queue_random_requests(50);
      wait_until_drained();

      write_modulus('1);
      queue_random_requests(50);
      wait_until_drained();

      write_modulus(32'd3);
      queue_random_requests(50);
      wait_until_drained();

      // Catch any stray result after the last one expected
      repeat (2300) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_step_unit.sv
rtl/core/mexp_engine.sv
rtl/core/modular_exponentiation_unit.sv
rtl/core/mexp_checker.sv
dv/tb_modular_exponentiation_unit.sv
